>>> rtl/two_link_arm_inverse_kinematics_assert.svh
// Assertion macros for the arm kinematics block.
// Each check is sampled on the rising edge of clk and is disabled while rst is high.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_ASSERT_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_ASSERT_SVH

`ifndef SYNTHESIS
`define TLIK_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TLIK_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TLIK_CHECK(lbl, ante, cons, msg)
`define TLIK_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/tlik_pkg.sv
`default_nettype none

package tlik_pkg;

  localparam int IN_W  = 19;
  localparam int LEN_W = 18;
  localparam int OPW   = 41;   // CORDIC operand magnitude width
  localparam int CW    = 44;   // CORDIC x/y datapath width
  localparam int ANG_W = 32;   // internal angle, 1/65536 degree

  localparam int NORM_STEPS      = 6;
  localparam int SQRT_STEPS      = 32;
  localparam int MAX_ITER        = 32;
  localparam int CORDIC_ITER_DEF = 16;

  localparam int DEG90     = 90 * 65536;
  localparam int DEG180    = 180 * 65536;
  localparam int ROUND_ADD = 256;
  localparam int WIN_MIN   = -45 * 128;
  localparam int WIN_MAX   = 345 * 128;
  localparam int ELBOW_MAX = 180 * 128;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_REACH  = 3'd1;
  localparam logic [2:0] ST_INNER  = 3'd2;
  localparam logic [2:0] ST_SHLDR  = 3'd3;
  localparam logic [2:0] ST_ELBOW  = 3'd4;

  localparam logic REG_INNER = 1'b0;
  localparam logic REG_OUTER = 1'b1;

  localparam int ATAN_TAB [MAX_ITER] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic signed [39:0]     num;
    logic signed [39:0]     p;
    logic [2:0]             sh;
    logic                   beyond;
    logic                   inner;
  } side_t;

  typedef struct packed {
    logic signed [IN_W-1:0] z;
    logic                   neg;
    logic                   add180;
    logic                   beyond;
    logic                   inner;
  } late_t;

endpackage

`default_nettype wire

>>> rtl/tlik_cordic.sv
`default_nettype none

module tlik_cordic import tlik_pkg::*; #(
  parameter int ITER = CORDIC_ITER_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire logic [OPW-1:0]          in_x,
  input  wire logic [OPW-1:0]          in_y,
  input  wire logic                    in_yneg,
  output logic                         out_valid,
  output logic signed [ANG_W-1:0]      out_angle
);

  localparam int LAT = NORM_STEPS + 1 + ITER;

  logic [OPW-1:0]          nx [NORM_STEPS];
  logic [OPW-1:0]          ny [NORM_STEPS];
  logic                    nneg [NORM_STEPS];
  logic                    nzero [NORM_STEPS];
  logic signed [CW-1:0]    cx [ITER+1];
  logic signed [CW-1:0]    cy [ITER+1];
  logic signed [ANG_W-1:0] cz [ITER+1];
  logic                    czero [ITER+1];
  logic [LAT-1:0]          vpipe;

  // Shift left by sh when the top sh bits of the pair are all clear.
  function automatic logic [OPW-1:0] nshift(input logic [OPW-1:0] v,
                                            input logic [OPW-1:0] o,
                                            input int sh);
    return ((o >> (OPW - sh)) == '0) ? (v << sh) : v;
  endfunction

  // The leading one of the pair is moved up to bit 40 in six binary steps.
  always_ff @(posedge clk) begin
    nx[0]    <= nshift(in_x, in_x | in_y, 32);
    ny[0]    <= nshift(in_y, in_x | in_y, 32);
    nneg[0]  <= in_yneg;
    nzero[0] <= ((in_x | in_y) == '0);
    for (int k = 1; k < NORM_STEPS; k++) begin
      nx[k]    <= nshift(nx[k-1], nx[k-1] | ny[k-1], 32 >> k);
      ny[k]    <= nshift(ny[k-1], nx[k-1] | ny[k-1], 32 >> k);
      nneg[k]  <= nneg[k-1];
      nzero[k] <= nzero[k-1];
    end
  end

  always_ff @(posedge clk) begin
    cx[0]    <= $signed({3'b000, nx[NORM_STEPS-1]});
    cy[0]    <= nneg[NORM_STEPS-1] ? -$signed({3'b000, ny[NORM_STEPS-1]})
                                   : $signed({3'b000, ny[NORM_STEPS-1]});
    cz[0]    <= '0;
    czero[0] <= nzero[NORM_STEPS-1];
    for (int i = 0; i < ITER; i++) begin
      if (!cy[i][CW-1]) begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ATAN_TAB[i];
      end else begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ATAN_TAB[i];
      end
      czero[i+1] <= czero[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vpipe[LAT-1];
  assign out_angle = czero[ITER] ? '0 : cz[ITER];

endmodule

`default_nettype wire

>>> rtl/two_link_arm_inverse_kinematics.sv
// Throughput: one item per cycle; busy stays low, as every stage advances each cycle.
// The depth is set by the 32-step square root and the three parallel CORDIC units.
// Reset (synchronous, active high) clears all valid bits and both link lengths.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
`include "two_link_arm_inverse_kinematics_assert.svh"

module two_link_arm_inverse_kinematics import tlik_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic signed [IN_W-1:0] target_x,
  input  wire logic signed [IN_W-1:0] target_y,
  input  wire logic signed [IN_W-1:0] target_z,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [LEN_W-1:0]       cfg_data,
  output logic                        done,
  output logic signed [16:0]          shoulder_angle,
  output logic [14:0]                 elbow_angle,
  output logic signed [IN_W-1:0]      height,
  output logic [2:0]                  status
);

  localparam int ITER  = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;
  localparam int FRONT = 5 + SQRT_STEPS + 2;
  localparam int LC    = NORM_STEPS + 1 + ITER;

  logic [LEN_W-1:0] len_inner;
  logic [LEN_W-1:0] len_outer;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_inner <= '0;
      len_outer <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_INNER) begin
        len_inner <= cfg_data;
      end else begin
        len_outer <= cfg_data;
      end
    end
  end

  logic [FRONT-1:0] vf;
  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= '0;
    end else begin
      vf <= {vf[FRONT-2:0], start & ~busy};
    end
  end

  // Stage 1: squares.
  logic signed [37:0]     xsq_full, ysq_full;
  logic [LEN_W:0]         lsum_c, ldif_c;
  logic [36:0]            s1_xx, s1_yy;
  logic [35:0]            s1_l1sq, s1_l2sq, s1_dif2;
  logic [37:0]            s1_sum2;
  logic                   s1_lz;
  logic signed [IN_W-1:0] s1_x, s1_y, s1_z;

  assign xsq_full = target_x * target_x;
  assign ysq_full = target_y * target_y;
  assign lsum_c   = {1'b0, len_inner} + {1'b0, len_outer};
  assign ldif_c   = (len_inner >= len_outer) ? {1'b0, len_inner - len_outer}
                                             : {1'b0, len_outer - len_inner};

  always_ff @(posedge clk) begin
    s1_xx   <= xsq_full[36:0];
    s1_yy   <= ysq_full[36:0];
    s1_l1sq <= len_inner * len_inner;
    s1_l2sq <= len_outer * len_outer;
    s1_sum2 <= lsum_c * lsum_c;
    s1_dif2 <= 36'(ldif_c[LEN_W-1:0] * ldif_c[LEN_W-1:0]);
    s1_lz   <= (len_inner == '0) || (len_outer == '0);
    s1_x    <= target_x;
    s1_y    <= target_y;
    s1_z    <= target_z;
  end

  // Stage 2: squared radius and link sums.
  logic [37:0]            s2_r2, s2_sum2;
  logic [36:0]            s2_lsq;
  logic signed [36:0]     s2_ldf;
  logic [35:0]            s2_dif2;
  logic                   s2_lz;
  logic signed [IN_W-1:0] s2_x, s2_y, s2_z;

  always_ff @(posedge clk) begin
    s2_r2   <= {1'b0, s1_xx} + {1'b0, s1_yy};
    s2_lsq  <= {1'b0, s1_l1sq} + {1'b0, s1_l2sq};
    s2_ldf  <= $signed({1'b0, s1_l1sq}) - $signed({1'b0, s1_l2sq});
    s2_sum2 <= s1_sum2;
    s2_dif2 <= s1_dif2;
    s2_lz   <= s1_lz;
    s2_x    <= s1_x;
    s2_y    <= s1_y;
    s2_z    <= s1_z;
  end

  // Stage 3: reach checks and the terms of the cosine rule.
  logic [37:0] s3_a, s3_b;
  side_t       s3_side;

  always_ff @(posedge clk) begin
    s3_a           <= s2_r2 - {2'b00, s2_dif2};
    s3_b           <= s2_sum2 - s2_r2;
    s3_side.num    <= $signed({2'b00, s2_r2}) - $signed({3'b000, s2_lsq});
    s3_side.p      <= $signed({2'b00, s2_r2}) + 40'(s2_ldf);
    s3_side.beyond <= s2_r2 > s2_sum2;
    s3_side.inner  <= (s2_r2 == '0) || s2_lz || (s2_r2 < {2'b00, s2_dif2});
    s3_side.x      <= s2_x;
    s3_side.y      <= s2_y;
    s3_side.z      <= s2_z;
    s3_side.sh     <= '0;
  end

  // Stage 4: bring each factor below 2^32 by an even shift.
  logic [1:0]  ha, hb;
  logic [31:0] s4_a, s4_b;
  side_t       s3_side_sh;
  side_t       s4_side;

  assign ha = (s3_a[37:36] != '0) ? 2'd3 : (s3_a[35:34] != '0) ? 2'd2 :
              (s3_a[33:32] != '0) ? 2'd1 : 2'd0;
  assign hb = (s3_b[37:36] != '0) ? 2'd3 : (s3_b[35:34] != '0) ? 2'd2 :
              (s3_b[33:32] != '0) ? 2'd1 : 2'd0;

  always_comb begin
    s3_side_sh    = s3_side;
    s3_side_sh.sh = {1'b0, ha} + {1'b0, hb};
  end

  always_ff @(posedge clk) begin
    s4_a    <= 32'(s3_a >> {ha, 1'b0});
    s4_b    <= 32'(s3_b >> {hb, 1'b0});
    s4_side <= s3_side_sh;
  end

  // Stage 5 and the square root: one result bit per stage.
  logic [63:0] sq_n [SQRT_STEPS+1];
  logic [63:0] sq_r [SQRT_STEPS+1];
  side_t       sd   [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    sq_n[0] <= s4_a * s4_b;
    sq_r[0] <= '0;
    sd[0]   <= s4_side;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (sq_n[k] >= sq_r[k] + (64'd1 << (62 - 2 * k))) begin
        sq_n[k+1] <= sq_n[k] - (sq_r[k] + (64'd1 << (62 - 2 * k)));
        sq_r[k+1] <= (sq_r[k] >> 1) + (64'd1 << (62 - 2 * k));
      end else begin
        sq_n[k+1] <= sq_n[k];
        sq_r[k+1] <= sq_r[k] >> 1;
      end
      sd[k+1] <= sd[k];
    end
  end

  logic [37:0] h_val;
  side_t       h_side;

  function automatic logic [2:0] h_side_sh(input side_t s);
    return s.sh;
  endfunction

  always_ff @(posedge clk) begin
    h_val  <= 38'(sq_r[SQRT_STEPS][31:0]) << h_side_sh(sd[SQRT_STEPS]);
    h_side <= sd[SQRT_STEPS];
  end

  // Operand selection for the three CORDIC units.
  logic [39:0]     num_mag, p_mag;
  logic [IN_W:0]   x_mag, y_mag;
  logic [OPW-1:0]  o3_x, o3_y, om_x, om_y, ob_x, ob_y;
  logic            ob_neg;
  late_t           o_late;

  assign num_mag = h_side.num[39] ? 40'(-h_side.num) : 40'(h_side.num);
  assign p_mag   = h_side.p[39] ? 40'(-h_side.p) : 40'(h_side.p);
  assign x_mag   = h_side.x[IN_W-1] ? -{h_side.x[IN_W-1], h_side.x}
                                    : {h_side.x[IN_W-1], h_side.x};
  assign y_mag   = h_side.y[IN_W-1] ? -{h_side.y[IN_W-1], h_side.y}
                                    : {h_side.y[IN_W-1], h_side.y};

  always_ff @(posedge clk) begin
    if (h_side.num[39]) begin
      o3_x <= {3'b000, h_val};
      o3_y <= {1'b0, num_mag};
    end else begin
      o3_x <= {1'b0, num_mag};
      o3_y <= {3'b000, h_val};
    end
    om_x   <= {3'b000, h_val};
    om_y   <= {1'b0, p_mag};
    ob_x   <= OPW'(x_mag);
    ob_y   <= OPW'(y_mag);
    // With x negative the vector is turned half a revolution first.
    ob_neg <= h_side.x[IN_W-1] ? (!h_side.y[IN_W-1] && (h_side.y != '0))
                               : h_side.y[IN_W-1];
    o_late.z      <= h_side.z;
    o_late.neg    <= h_side.num[39];
    o_late.add180 <= h_side.x[IN_W-1] && !h_side.y[IN_W-1] && (h_side.y != '0);
    o_late.beyond <= h_side.beyond;
    o_late.inner  <= h_side.inner;
  end

  logic [2:0]              c_v;
  logic signed [ANG_W-1:0] z3, zm, zb;

  tlik_cordic #(.ITER(ITER)) u_elbow (
    .clk(clk), .rst(rst), .in_valid(vf[FRONT-1]),
    .in_x(o3_x), .in_y(o3_y), .in_yneg(1'b0),
    .out_valid(c_v[0]), .out_angle(z3)
  );

  tlik_cordic #(.ITER(ITER)) u_asin (
    .clk(clk), .rst(rst), .in_valid(vf[FRONT-1]),
    .in_x(om_x), .in_y(om_y), .in_yneg(1'b0),
    .out_valid(c_v[1]), .out_angle(zm)
  );

  tlik_cordic #(.ITER(ITER)) u_base (
    .clk(clk), .rst(rst), .in_valid(vf[FRONT-1]),
    .in_x(ob_x), .in_y(ob_y), .in_yneg(ob_neg),
    .out_valid(c_v[2]), .out_angle(zb)
  );

  late_t ld [LC];
  always_ff @(posedge clk) begin
    ld[0] <= o_late;
    for (int k = 1; k < LC; k++) begin
      ld[k] <= ld[k-1];
    end
  end

  // Final stages: angle assembly, rounding, clamp and status.
  logic                    f1_v, f2_v;
  logic signed [ANG_W-1:0] f1_t1, f1_t3, t1_rnd, t3_rnd;
  late_t                   f1_late, f2_late;
  logic signed [22:0]      f2_sh, f2_el;
  logic [14:0]             el_clamp;
  logic                    sh_out, el_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      done <= 1'b0;
    end else begin
      f1_v <= c_v[0];
      f2_v <= f1_v;
      done <= f2_v;
    end
  end

  always_ff @(posedge clk) begin
    f1_t3   <= z3 + (ld[LC-1].neg ? DEG90 : 0);
    f1_t1   <= zb - zm + (ld[LC-1].add180 ? DEG180 : 0);
    f1_late <= ld[LC-1];
  end

  assign t1_rnd = f1_t1 + ROUND_ADD;
  assign t3_rnd = f1_t3 + ROUND_ADD;

  always_ff @(posedge clk) begin
    f2_sh   <= t1_rnd[31:9];
    f2_el   <= t3_rnd[31:9];
    f2_late <= f1_late;
  end

  assign el_clamp = f2_el[22] ? '0 : (f2_el > ELBOW_MAX) ? 15'(ELBOW_MAX) : f2_el[14:0];
  assign sh_out   = (f2_sh < WIN_MIN) || (f2_sh > WIN_MAX);
  assign el_out   = ($signed({8'd0, el_clamp}) < WIN_MIN) ||
                    ($signed({8'd0, el_clamp}) > WIN_MAX);

  always_ff @(posedge clk) begin
    height <= f2_late.z;
    if (f2_late.beyond || f2_late.inner) begin
      shoulder_angle <= '0;
      elbow_angle    <= '0;
      status         <= f2_late.beyond ? ST_REACH : ST_INNER;
    end else begin
      shoulder_angle <= f2_sh[16:0];
      elbow_angle    <= el_clamp;
      status         <= sh_out ? ST_SHLDR : (el_out ? ST_ELBOW : ST_OK);
    end
  end

  `TLIK_CHECK(a_units_aligned, c_v != 3'b000, c_v == 3'b111, "CORDIC units out of step")
  `TLIK_CHECK(a_status_code, done, status <= ST_ELBOW, "status code out of range")
  `TLIK_CHECK(a_fail_zero, done && (status == ST_REACH || status == ST_INNER),
              shoulder_angle == '0 && elbow_angle == '0, "failed item carries angles")
  `TLIK_CHECK(a_elbow_range, done, elbow_angle <= 15'(ELBOW_MAX), "elbow beyond half turn")
  `TLIK_CHECK(a_ok_window, done && status == ST_OK,
              shoulder_angle >= WIN_MIN && shoulder_angle <= WIN_MAX,
              "accepted shoulder angle outside window")
  `TLIK_CHECK_NEXT(a_done_flow, f2_v, done, "result strobe lost")

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import tlik_pkg::*;

  typedef struct {
    logic signed [16:0]     shoulder;
    logic [14:0]            elbow;
    logic signed [IN_W-1:0] height;
    logic [2:0]             status;
  } joint_set_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic signed [IN_W-1:0] target_x;
  logic signed [IN_W-1:0] target_y;
  logic signed [IN_W-1:0] target_z;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_index;
  logic [LEN_W-1:0]       cfg_data;
  logic                   done;
  logic signed [16:0]     shoulder_angle;
  logic [14:0]            elbow_angle;
  logic signed [IN_W-1:0] height;
  logic [2:0]             status;

  two_link_arm_inverse_kinematics u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .shoulder_angle(shoulder_angle),
    .elbow_angle(elbow_angle), .height(height), .status(status)
  );

  localparam int PIPE_DEPTH = CORDIC_ITER_DEF + 49;

  joint_set_t  pending_joints[$];
  longint      inner_len;
  longint      outer_len;
  int          mismatch_count;
  int          item_count;
  int          result_count;
  int          status_seen[5];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Square root of a*b, each factor scaled down by an even shift to fit 32 bits.
  function automatic longint unsigned root_of_product(longint unsigned a, longint unsigned b);
    int sa;
    int sb;
    sa = 0;
    sb = 0;
    while ((a >> sa) >= (64'd1 << 32)) sa += 2;
    while ((b >> sb) >= (64'd1 << 32)) sb += 2;
    return int_sqrt((a >> sa) * (b >> sb)) << ((sa + sb) / 2);
  endfunction

  // Vectoring CORDIC angle of (x, y) with x >= 0, in 1/65536 degree.
  function automatic longint vector_angle(longint x, longint y);
    longint unsigned mx;
    longint unsigned my;
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint acc;
    int     n;
    mx = x;
    my = (y < 0) ? -y : y;
    acc = 0;
    n = (CORDIC_ITER_DEF > MAX_ITER) ? MAX_ITER : CORDIC_ITER_DEF;
    if ((mx | my) == 0) return 0;
    while ((mx | my) < (64'd1 << 40)) begin
      mx = mx << 1;
      my = my << 1;
    end
    cx = mx;
    cy = (y < 0) ? -longint'(my) : longint'(my);
    for (int i = 0; i < n; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        acc += ATAN_TAB[i];
      end else begin
        cx -= dx;
        cy += dy;
        acc -= ATAN_TAB[i];
      end
    end
    return acc;
  endfunction

  function automatic joint_set_t solve_joints(logic signed [IN_W-1:0] tx,
                                              logic signed [IN_W-1:0] ty,
                                              logic signed [IN_W-1:0] tz);
    joint_set_t js;
    longint x;
    longint y;
    longint r2;
    longint sum;
    longint dif;
    longint num;
    longint p;
    longint h;
    longint t1;
    longint t3;
    longint sh;
    longint el;
    x = tx;
    y = ty;
    r2 = x * x + y * y;
    sum = inner_len + outer_len;
    dif = inner_len - outer_len;
    sh = 0;
    el = 0;
    js.status = ST_OK;
    if (r2 > sum * sum) begin
      js.status = ST_REACH;
    end else if (r2 == 0 || inner_len == 0 || outer_len == 0 || r2 < dif * dif) begin
      js.status = ST_INNER;
    end else begin
      num = r2 - inner_len * inner_len - outer_len * outer_len;
      p = r2 + inner_len * inner_len - outer_len * outer_len;
      h = root_of_product(r2 - dif * dif, sum * sum - r2);
      if (num >= 0) t3 = vector_angle(num, h);
      else t3 = DEG90 + vector_angle(h, -num);
      t1 = ((x >= 0) ? vector_angle(x, y) : vector_angle(-x, -y))
           - vector_angle(h, (p < 0) ? -p : p);
      if (x < 0 && y > 0) t1 += DEG180;
      sh = (t1 + ROUND_ADD) >>> 9;
      el = (t3 + ROUND_ADD) >>> 9;
      if (el < 0) el = 0;
      if (el > ELBOW_MAX) el = ELBOW_MAX;
      if (sh < WIN_MIN || sh > WIN_MAX) js.status = ST_SHLDR;
      else if (el < WIN_MIN || el > WIN_MAX) js.status = ST_ELBOW;
    end
    js.shoulder = sh[16:0];
    js.elbow = el[14:0];
    js.height = tz;
    return js;
  endfunction

  // Results arrive one per strobe and cannot be held off.
  always @(posedge clk) begin
    joint_set_t want;
    if (!rst && done) begin
      result_count++;
      if (pending_joints.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Result with no item outstanding at %0t", $time);
      end else begin
        want = pending_joints.pop_front();
        if (status < 5) status_seen[status]++;
        if (shoulder_angle !== want.shoulder || elbow_angle !== want.elbow ||
            height !== want.height || status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch at %0t: exp sh=%0d el=%0d h=%0d st=%0d, got sh=%0d el=%0d h=%0d st=%0d",
                     $time, want.shoulder, want.elbow, want.height, want.status,
                     shoulder_angle, elbow_angle, height, status);
        end
      end
    end
  end

  task automatic send_target(logic signed [IN_W-1:0] tx, logic signed [IN_W-1:0] ty,
                             logic signed [IN_W-1:0] tz);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    target_x <= tx;
    target_y <= ty;
    target_z <= tz;
    do @(posedge clk); while (busy);
    pending_joints.push_back(solve_joints(tx, ty, tz));
    item_count++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_joints.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  // The write strobe is left high; the caller drops it after the last write.
  task automatic write_length(logic idx, logic [LEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_INNER) inner_len = value;
    else outer_len = value;
  endtask

  task automatic set_links(logic [LEN_W-1:0] l1, logic [LEN_W-1:0] l2);
    drain();
    write_length(REG_INNER, l1);
    write_length(REG_OUTER, l2);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [IN_W-1:0] coord_within(longint span);
    longint v;
    if (span > 262143) span = 262143;
    v = longint'($urandom_range(0, 2 * span)) - span;
    return v[IN_W-1:0];
  endfunction

  task automatic test_directed;
    set_links(25600, 25600);
    send_target(0, 0, -262144);                 // origin
    send_target(262143, 262143, 262143);        // far corner, beyond reach
    send_target(-262144, -262144, 0);
    send_target(0, 30000, 5);                   // on the y axis
    send_target(0, -30000, -5);
    send_target(30000, 0, 1);
    send_target(-30000, 20000, 2);              // second quadrant gets 180 added
    send_target(-30000, -20000, 3);
    send_target(51200, 0, 4);                   // fully stretched
    send_target(1, 0, 6);
    send_target(20000, -40000, 7);              // shoulder well below the window
    send_target(-1, 1, 8);
    set_links(30000, 10000);
    send_target(100, 100, 9);                   // inside the dead zone
    send_target(20000, 0, 10);                  // on the inner boundary
    send_target(-40000, 0, 11);
  endtask

  task automatic test_zero_lengths;
    set_links(0, 20000);
    send_target(10000, 10000, 12);
    set_links(20000, 0);
    send_target(20000, 0, 13);
    send_target(-5000, 3000, 14);
  endtask

  task automatic test_random(logic [LEN_W-1:0] l1, logic [LEN_W-1:0] l2, int count);
    longint span;
    set_links(l1, l2);
    span = longint'(l1) + longint'(l2);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_target(coord_within(span), coord_within(span), IN_W'($urandom));
      else
        send_target(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    target_x = '0;
    target_y = '0;
    target_z = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_INNER;
    cfg_data = '0;
    inner_len = 0;
    outer_len = 0;
    mismatch_count = 0;
    item_count = 0;
    result_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_lengths();
    test_random(25600, 25600, 150);
    test_random(262143, 262143, 120);
    test_random(1, 1, 60);
    test_random(40000, 15000, 150);
    test_random(LEN_W'($urandom_range(1, 262143)), LEN_W'($urandom_range(1, 262143)), 170);
    drain();
    $display("Covered %0d targets and %0d results over several link settings.",
             item_count, result_count);
    $display("Status counts: ok %0d, reach %0d, inner %0d, shoulder %0d, elbow %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_count == 0 && pending_joints.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
